[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is applied
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while reset is applied
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[src/dsc_pkg.sv]
// ----------------------------------------------------------------------------
// dsc_pkg
// constants and types shared by the distinct subsequence counter
// ----------------------------------------------------------------------------
package dsc_pkg;

	localparam int MAX_LEN  = 64;
	localparam int ALPHABET = 26;

	localparam int CNT_W    = 30;
	localparam int SYM_W    = 5;
	localparam int LEN_W    = 7;
	localparam int LETTER_W = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

	localparam logic [CNT_W-1:0] MODULUS = CNT_W'(1000000007);

	// control broadcast from the top level to every length cell
	typedef struct packed {
		logic                step;   // an item is transferred this cycle
		logic                clear;  // start of a new string
		logic                take;   // symbol is inside the alphabet
		logic [LETTER_W-1:0] letter;
	} cell_ctrl_t;

endpackage

[src/dsc_cell.sv]
// ----------------------------------------------------------------------------
// dsc_cell
// one length column: its count and the per-letter last contributions
// ----------------------------------------------------------------------------
module dsc_cell import dsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cell_ctrl_t       ctrl,
	input  logic [CNT_W-1:0] prev_count,
	output logic [CNT_W-1:0] cur_count,
	output logic [CNT_W-1:0] next_count
);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    last_q [ALPHABET];

	logic [CNT_W-1:0]    last_val;
	logic [CNT_W:0]      diff;
	logic [CNT_W-1:0]    diff_mod;
	logic [CNT_W:0]      sum;
	logic [CNT_W-1:0]    sum_mod;

	// count as seen by this item, after an optional restart
	assign cur_count = ctrl.clear ? '0 : count_q;

	// last contribution of this letter, zero right after a restart
	assign last_val = (ctrl.take && !ctrl.clear) ? last_q[ctrl.letter] : '0;

	// old - last mod p, then + neighbour mod p
	always_comb begin
		diff     = {1'b0, cur_count} - {1'b0, last_val};
		diff_mod = diff[CNT_W] ? (diff[CNT_W-1:0] + MODULUS) : diff[CNT_W-1:0];
		sum      = {1'b0, diff_mod} + {1'b0, prev_count};
		sum_mod  = (sum >= {1'b0, MODULUS}) ? CNT_W'(sum - {1'b0, MODULUS}) :
			sum[CNT_W-1:0];
	end

	assign next_count = ctrl.take ? sum_mod : cur_count;

	// column count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.step) begin
			count_q <= next_count;
		end
	end

	// per-letter store of the neighbour count, emptied on restart
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < ALPHABET; l++) begin
				last_q[l] <= '0;
			end
		end else if (ctrl.step) begin
			for (int l = 0; l < ALPHABET; l++) begin
				if (ctrl.take && (ctrl.letter == LETTER_W'(l))) begin
					last_q[l] <= prev_count;
				end else if (ctrl.clear) begin
					last_q[l] <= '0;
				end
			end
		end
	end

endmodule

[src/distinct_subsequence_counter.sv]
// ----------------------------------------------------------------------------
// distinct_subsequence_counter
// distinct subsequence counts by length, modulo 1000000007
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_ready carry one letter (symbol, 0..25) and a
// start_new flag that restarts the string before this letter. Letters
// outside the alphabet leave all counts unchanged.
// Output channel: out_valid / out_ready carry distinct_count, the number of
// distinct subsequences of the configured length of the string so far.
// Exactly one result follows every input transfer, in the cycle after it.
// Throughput is one item per cycle: a row of one cell per length updates
// every column in the same cycle from the previous column's count.
// The result register accepts a new item while its result is being
// transferred; when the receiver stalls, in_ready falls until it drains.
// Configuration: cfg_valid / cfg_ready write target_length (always ready); the
// user, not the block, ensures this is done only while no item is in flight.
// Lengths above 64 report zero. Reset: counts return to the empty string
// (length zero counts one), target_length returns to one and the output register is empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module distinct_subsequence_counter import dsc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [SYM_W-1:0] symbol,
	input  logic             start_new,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CNT_W-1:0] distinct_count,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] target_length
);

	logic [LEN_W-1:0] target_q;
	logic             out_valid_q;
	logic [CNT_W-1:0] count_q;

	cell_ctrl_t       ctrl;
	logic             in_xfer;
	logic [CNT_W-1:0] cur   [MAX_LEN+1];
	logic [CNT_W-1:0] nxt   [MAX_LEN+1];
	logic [CNT_W-1:0] sel_count;

	assign in_ready  = !out_valid_q || out_ready;
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// control shared by all cells
	always_comb begin
		ctrl.step   = in_xfer;
		ctrl.clear  = start_new;
		ctrl.take   = (symbol < SYM_W'(ALPHABET));
		ctrl.letter = LETTER_W'(symbol);
	end

	// length zero: the empty subsequence
	assign cur[0] = CNT_W'(1);
	assign nxt[0] = CNT_W'(1);

	// row of length cells, each fed by its lower neighbour
	for (genvar j = 1; j <= MAX_LEN; j++) begin : g_cell
		dsc_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_count (cur[j-1]),
			.cur_count  (cur[j]),
			.next_count (nxt[j])
		);
	end

	// pick the updated count of the target length
	always_comb begin
		sel_count = '0;
		for (int j = 0; j <= MAX_LEN; j++) begin
			if (target_q == LEN_W'(j)) begin
				sel_count = sel_count | nxt[j];
			end
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			target_q <= target_length;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			count_q <= sel_count;
		end
	end

	assign out_valid      = out_valid_q;
	assign distinct_count = count_q;

	// every accepted item leaves a result behind
	`ASSERT_NEXT(a_result_follows, clk, arst_n, in_xfer, out_valid_q)
	// reported counts are reduced
	`ASSERT_IMP(a_count_reduced, clk, arst_n, out_valid_q, count_q < MODULUS)
	// target length zero always reports the empty subsequence
	`ASSERT_NEXT(a_len_zero, clk, arst_n, in_xfer && (target_q == '0), count_q == CNT_W'(1))

endmodule
